FILE: rtl/itoar_pkg.sv
// shared types, character constants and digit-to-ascii mapping
package itoar_pkg;

    localparam int RADIX_BITS = 6;
    localparam int CHAR_BITS  = 7;

    localparam logic [RADIX_BITS-1:0] MIN_RADIX = 6'd2;
    localparam logic [RADIX_BITS-1:0] MAX_RADIX = 6'd36;
    localparam logic [RADIX_BITS-1:0] DEC_RADIX = 6'd10;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 7'h2d;

    localparam logic [RADIX_BITS-1:0] MAX_DEC_DIGIT = 6'd9;
    localparam logic [CHAR_BITS-1:0]  LETTER_OFFSET = 7'd10;

    typedef logic [RADIX_BITS-1:0] digit_t;
    typedef logic [CHAR_BITS-1:0]  ascii_t;

    // sequencer to divider
    typedef struct packed {
        logic   start;
        digit_t divisor;
    } div_ctl_t;

    // divider to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic ascii_t digit_char(input digit_t d);
        ascii_t dx;
        dx = {1'b0, d};
        if (d > MAX_DEC_DIGIT)
            return dx - LETTER_OFFSET + CHAR_LOWER_A;
        return dx + CHAR_ZERO;
    endfunction

endpackage

FILE: rtl/itoar_ram.sv
// generic single-write, single-read ram with registered read data
module itoar_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/itoar_divider.sv
// iterative restoring divider, one quotient bit per cycle, small divisor
module itoar_divider #(
    parameter int WORD_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  itoar_pkg::div_ctl_t      ctl,
    input  logic [WORD_BITS-1:0]     dividend,
    output itoar_pkg::div_stat_t     stat,
    output logic [WORD_BITS-1:0]     quotient,
    output itoar_pkg::digit_t        remainder
);

    localparam int CW = $clog2(WORD_BITS);
    localparam int RB = itoar_pkg::RADIX_BITS;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] quo_reg, quo_next;
    logic [RB-1:0]        rem_reg, rem_next;
    logic [RB-1:0]        dvs_reg, dvs_next;

    logic [RB:0]          shifted;
    logic [RB+1:0]        trial;

    // shift one dividend bit into the partial remainder and try the subtract
    assign shifted = {rem_reg, quo_reg[WORD_BITS-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (ctl.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(WORD_BITS - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = ctl.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[RB+1])
            begin
                rem_next = trial[RB-1:0];
                quo_next = {quo_reg[WORD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[RB-1:0];
                quo_next = {quo_reg[WORD_BITS-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/integer_to_ascii_radix_core.sv
// top level: integer to ascii text in radix 2..36, msd first, signed in base 10 only
//
//  channel | signals                          | dir | beat
//  --------+----------------------------------+-----+------------------------------
//  input   | in_valid, in_stall, number_in,   | in  | one number and its radix
//          | radix                            |     |
//  output  | out_valid, out_stall, char_out,  | out | one ascii character, last_char
//          | last_char                        |     | set on the final one
//
//  one number divides out its digits one by one through the shared bit-serial
//  divider; each digit character then takes ram read, output load and hand-off,
//  a leading '-' takes output load and hand-off, plus any output stall
//  in_stall is high after the accepted input beat until the last character leaves
//  out_stall holds the output register and the sequencer in its hand-off state; the payload stays put while stalled
//  reset clears the sequencer, the divider control and the output valid flag;
//  the digit ram is not cleared, every entry is written before it is read
module integer_to_ascii_radix_core #(
    parameter int WORD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] number_in,
    input  logic [5:0]  radix,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  char_out,
    output logic        last_char
);

    localparam int AW  = $clog2(WORD_BITS);
    localparam int CNW = $clog2(WORD_BITS + 1);
    localparam int RB  = itoar_pkg::RADIX_BITS;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [CNW-1:0]        cnt_reg, cnt_next;
    logic [WORD_BITS-1:0]  quo_reg, quo_next;
    logic [RB-1:0]         radix_reg, radix_next;
    logic                  neg_reg, neg_next;
    logic                  ovalid_reg, ovalid_next;
    itoar_pkg::ascii_t     char_reg, char_next;
    logic                  last_reg, last_next;

    logic signed [31:0]    num_s;
    logic [WORD_BITS-1:0]  word;
    logic [WORD_BITS-1:0]  mag;
    logic [RB-1:0]         radix_cl;
    logic                  is_neg;
    logic                  in_take;
    logic                  out_take;
    logic [CNW-1:0]        cnt_dec;

    itoar_pkg::div_ctl_t   div_ctl;
    itoar_pkg::div_stat_t  div_stat;
    logic [WORD_BITS-1:0]  div_quo;
    itoar_pkg::digit_t     div_rem;

    logic                  ram_we;
    itoar_pkg::digit_t     ram_rdata;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    // out-of-range radix codes clamp to the nearest legal base
    always_comb
    begin
        if (radix < itoar_pkg::MIN_RADIX)
            radix_cl = itoar_pkg::MIN_RADIX;
        else if (radix > itoar_pkg::MAX_RADIX)
            radix_cl = itoar_pkg::MAX_RADIX;
        else
            radix_cl = radix;
    end

    // sign-extend (or truncate) to the word, then take the unsigned magnitude
    // in base 10 only; the most negative value negates to itself as unsigned
    assign num_s  = number_in;
    assign word   = WORD_BITS'(num_s);
    assign is_neg = (radix_cl == itoar_pkg::DEC_RADIX) && word[WORD_BITS-1];
    assign mag    = is_neg ? ('0 - word) : word;

    assign cnt_dec = cnt_reg - 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        quo_next    = quo_reg;
        radix_next  = radix_reg;
        neg_next    = neg_reg;
        ovalid_next = ovalid_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        div_ctl.start   = 1'b0;
        div_ctl.divisor = radix_reg;
        ram_we      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    quo_next   = mag;
                    radix_next = radix_cl;
                    neg_next   = is_neg;
                    cnt_next   = '0;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                div_ctl.start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                // each finished division leaves one digit, least significant first
                if (div_stat.done)
                begin
                    ram_we   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    quo_next = div_quo;
                    if (div_quo == '0)
                        state_next = neg_reg ? S_SIGN : S_RD;
                    else
                        state_next = S_START;
                end
            end
            S_SIGN:
            begin
                char_next   = itoar_pkg::CHAR_MINUS;
                last_next   = 1'b0;
                ovalid_next = 1'b1;
                state_next  = S_OUT;
            end
            S_RD:
            begin
                // ram address is cnt_dec, data lands in the next cycle
                cnt_next   = cnt_dec;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                char_next   = itoar_pkg::digit_char(ram_rdata);
                last_next   = (cnt_reg == '0);
                ovalid_next = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    ovalid_next = 1'b0;
                    state_next  = last_reg ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            quo_reg    <= '0;
            neg_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            quo_reg    <= quo_next;
            neg_reg    <= neg_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg <= radix_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    itoar_divider #(
        .WORD_BITS (WORD_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (quo_reg),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    itoar_ram #(
        .WIDTH (RB),
        .DEPTH (WORD_BITS)
    ) u_digit_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (div_rem),
        .raddr (cnt_dec[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;
    assign char_out  = char_reg;
    assign last_char = last_reg;

    // a character is only presented while the sequencer waits on the hand-off
    a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == S_OUT))
        else $error("output valid outside hand-off state");

    // the divider is never restarted while still iterating
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.start |-> !div_stat.busy)
        else $error("divider started while busy");

    // the final character frees the input side on the next cycle
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && last_char) |=> !in_stall)
        else $error("input not released after last character");

    // digit count never exceeds the store depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (cnt_reg < CNW'(WORD_BITS)))
        else $error("digit store overflow");

endmodule

FILE: sim/tb_top.sv
// testbench for the integer to ascii text core: random and directed numbers, checked per character
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // run limits, in clock cycles
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES = 1200;
    localparam int unsigned RESET_CYCLES = 11;

    // one number to convert, as offered on the input channel
    typedef struct packed {
        logic [31:0] value;
        logic [5:0]  base;
    } num_item_t;

    // one expected character beat
    typedef struct packed {
        itoar_pkg::ascii_t ch;
        logic              last;
    } text_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] number_in = '0;
    logic [5:0]  radix = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [6:0]  char_out;
    logic        last_char;

    integer_to_ascii_radix_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .number_in (number_in),
        .radix     (radix),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_out  (char_out),
        .last_char (last_char)
    );

    num_item_t   pending_numbers[$];
    text_char_t  expected_chars[$];
    num_item_t   next_number;

    // idle chance per cycle, in percent, for each side
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;

    int unsigned items_issued = 0;
    int unsigned items_accepted = 0;
    int unsigned chars_checked = 0;
    int unsigned signed_numbers = 0;
    int unsigned clamped_radices = 0;
    int unsigned long_texts = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    logic        in_taken = 1'b0;
    logic        hold_req = 1'b0;
    int unsigned hold_left = 0;

    // free-running clock, 2 ns period
    initial
    begin
        forever #1 clk = ~clk;
    end

    // expected text for one number: clamp the radix, split off the sign in base 10,
    // divide digits out lsd first, then queue them msd first with last on the final one
    task automatic predict_text(input logic [31:0] value, input logic [5:0] base);
        int unsigned mag;
        int unsigned r;
        int unsigned digits[32];
        int          n;
        text_char_t  c;
        r = 32'(base);
        if (r < itoar_pkg::MIN_RADIX || r > itoar_pkg::MAX_RADIX)
            clamped_radices++;
        if (r < itoar_pkg::MIN_RADIX)
            r = 32'(itoar_pkg::MIN_RADIX);
        if (r > itoar_pkg::MAX_RADIX)
            r = 32'(itoar_pkg::MAX_RADIX);
        mag = value;
        // sign only in base 10; the magnitude is unsigned so the most negative value fits
        if (r == itoar_pkg::DEC_RADIX && value[31])
        begin
            mag = 32'd0 - value;
            c.ch = itoar_pkg::CHAR_MINUS;
            c.last = 1'b0;
            expected_chars.push_back(c);
            signed_numbers++;
        end
        n = 0;
        do
        begin
            digits[n] = mag % r;
            n++;
            mag = mag / r;
        end while (mag != 0);
        if (n > 16)
            long_texts++;
        for (int i = n - 1; i >= 0; i--)
        begin
            if (digits[i] > itoar_pkg::MAX_DEC_DIGIT)
                c.ch = itoar_pkg::CHAR_LOWER_A + itoar_pkg::ascii_t'(digits[i] - 10);
            else
                c.ch = itoar_pkg::CHAR_ZERO + itoar_pkg::ascii_t'(digits[i]);
            c.last = (i == 0);
            expected_chars.push_back(c);
        end
    endtask

    // input beat accepted: note it for the driver and predict its text
    always @(posedge clk)
    begin
        in_taken <= in_valid && !in_stall;
        if (in_valid && !in_stall)
        begin
            predict_text(number_in, radix);
            items_accepted++;
        end
    end

    // sender: a payload stays put until taken; idling is random and never looks at stall
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pending_numbers.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                next_number = pending_numbers.pop_front();
                in_valid  <= 1'b1;
                number_in <= next_number.value;
                radix     <= next_number.base;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // long receiver hold-off, counted here; loaded on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
    end

    // receiver: random stalls plus the hold-off
    always @(negedge clk)
    begin
        out_stall <= (hold_left != 0) || ($urandom_range(99) < rx_idle_pct);
    end

    // character beat taken: compare with the oldest expectation
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("unexpected character beat: char_out %h last_char %b",
                       char_out, last_char);
                fail_count++;
            end
            else
            begin
                if (char_out !== expected_chars[0].ch)
                begin
                    $error("char_out mismatch: expected %h, actual %h",
                           expected_chars[0].ch, char_out);
                    fail_count++;
                end
                if (last_char !== expected_chars[0].last)
                begin
                    $error("last_char mismatch: expected %b, actual %b",
                           expected_chars[0].last, last_char);
                    fail_count++;
                end
                void'(expected_chars.pop_front());
                chars_checked++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d characters still expected",
                     cycle_count, expected_chars.size());
            $display("** integer_to_ascii_radix_core: FAILED **");
            $finish;
        end
    end

    task automatic queue_number(input logic [31:0] value, input logic [5:0] base);
        num_item_t it;
        it.value = value;
        it.base = base;
        pending_numbers.push_back(it);
        items_issued++;
    endtask

    // random number: full words, small values of either sign, values near the extremes,
    // shifted words for mid-length text; radix mostly in range, base 10 favored
    task automatic queue_random_number();
        logic [31:0] v;
        logic [5:0]  b;
        case ($urandom_range(9)) inside
            0, 1, 2: v = $urandom;
            3, 4:    v = $urandom_range(999);
            5, 6:    v = 32'd0 - $urandom_range(1000, 1);
            7:       v = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                           : 32'h7fff_ffff - $urandom_range(3);
            default: v = $urandom >> $urandom_range(31);
        endcase
        case ($urandom_range(9)) inside
            0:       b = 6'($urandom_range(63));
            1, 2:    b = itoar_pkg::DEC_RADIX;
            default: b = 6'($urandom_range(36, 2));
        endcase
        queue_number(v, b);
    endtask

    // the test waits until every queued number has been fully answered
    task automatic wait_drained();
        while (items_accepted != items_issued || expected_chars.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int unsigned mark;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // phase one: sender idles a little, receiver a lot
        tx_idle_pct = 17;
        rx_idle_pct = 74;

        // zero in several bases
        queue_number(32'd0, itoar_pkg::DEC_RADIX);
        queue_number(32'd0, itoar_pkg::MIN_RADIX);
        queue_number(32'd0, itoar_pkg::MAX_RADIX);
        // small values: single digits, including the highest digit and letters, and two-digit texts
        queue_number(32'd1, itoar_pkg::MIN_RADIX);
        queue_number(32'd9, itoar_pkg::DEC_RADIX);
        queue_number(32'd35, itoar_pkg::MAX_RADIX);
        queue_number(32'd36, itoar_pkg::MAX_RADIX);
        queue_number(32'd10, 6'd11);
        queue_number(32'd255, 6'd16);
        // negative: sign in base 10, raw pattern elsewhere
        queue_number(32'hffff_ffff, itoar_pkg::DEC_RADIX);
        queue_number(32'hffff_ffff, itoar_pkg::MIN_RADIX);
        queue_number(32'hffff_ffff, 6'd16);
        queue_number(32'hffff_ffff, itoar_pkg::MAX_RADIX);
        queue_number(32'd0 - 32'd123, itoar_pkg::DEC_RADIX);
        queue_number(32'd0 - 32'd123, 6'd8);
        // most negative and most positive values
        queue_number(32'h8000_0000, itoar_pkg::DEC_RADIX);
        queue_number(32'h8000_0000, itoar_pkg::MIN_RADIX);
        queue_number(32'h8000_0001, itoar_pkg::DEC_RADIX);
        queue_number(32'h7fff_ffff, itoar_pkg::DEC_RADIX);
        queue_number(32'h7fff_ffff, itoar_pkg::MAX_RADIX);
        queue_number(32'h7fff_ffff, itoar_pkg::MIN_RADIX);
        // radix out of range on both sides
        queue_number(32'd5, 6'd0);
        queue_number(32'd5, 6'd1);
        queue_number(32'd100, 6'd63);
        queue_number(32'd100, 6'd37);

        for (int i = 0; i < 45; i++)
            queue_random_number();
        wait_drained();

        // phase two: the other way round
        tx_idle_pct = 74;
        rx_idle_pct = 17;
        for (int i = 0; i < 45; i++)
            queue_random_number();
        wait_drained();

        // phase three: no idling, with a long receiver hold-off mid-stream
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        mark = items_issued;
        for (int i = 0; i < 45; i++)
            queue_random_number();
        while (items_accepted < mark + 3)
            @(negedge clk);
        hold_req = 1'b1;
        while (hold_left == 0)
            @(negedge clk);
        hold_req = 1'b0;
        wait_drained();

        // let any stray beat show up before closing
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("converted %0d numbers into %0d characters in %0d cycles",
                 items_accepted, chars_checked, cycle_count);
        $display("%0d signed base-10 texts, %0d clamped radices, %0d texts over 16 digits",
                 signed_numbers, clamped_radices, long_texts);
        if (fail_count == 0)
            $display("** integer_to_ascii_radix_core: PASSED **");
        else
            $display("** integer_to_ascii_radix_core: FAILED **");
        $finish;
    end

endmodule
